FILE: hw/rtl/tsrmm_pkg.sv
// ============================================================================
// tsrmm_pkg
// Shared types and constants of the timed sample ring with per-lane min/max.
// ============================================================================
`default_nettype none

package tsrmm_pkg;

    localparam int DEPTH   = 64;
    localparam int LANES   = 4;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int LANE_W  = (LANES > 1) ? $clog2(LANES) : 1;
    localparam int LCNT_W  = $clog2(LANES + 1);
    localparam int VAL_W   = 32;
    localparam int STAMP_W = 32;

    localparam int WIN_REG_W  = 7;
    localparam int LANE_REG_W = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;

    localparam int IN_TDATA_W  = 208;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;
    localparam int OUT_TUSER_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LANES  = 2'd1;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_MINMAX = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_MISMATCH = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_RANGE    = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_SCAN  = 2'd1,
        S_DRAIN = 2'd2,
        S_EMIT  = 2'd3
    } state_t;

    typedef enum logic [1:0] {
        SRC_ZERO   = 2'd0,
        SRC_READ   = 2'd1,
        SRC_MINMAX = 2'd2
    } src_t;

    typedef struct packed {
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              acc_en;
        logic              acc_first;
    } lane_ctrl_t;

    typedef struct packed {
        logic               load;
        status_t            status;
        logic [CNT_W-1:0]   count;
        logic [STAMP_W-1:0] stamp;
        logic [LANE_W-1:0]  lane;
        logic               last;
        src_t               src;
    } out_load_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tsrmm_lane.sv
// ============================================================================
// tsrmm_lane
// One value lane: sample memory with registered read and a min/max tracker.
// ============================================================================
`default_nettype none

module tsrmm_lane (
    input  wire logic                                aclk,
    input  wire tsrmm_pkg::lane_ctrl_t               ctrl,
    input  wire logic                                wr_en,
    input  wire logic signed [tsrmm_pkg::VAL_W-1:0] wr_data,
    output logic signed [tsrmm_pkg::VAL_W-1:0]      rd_data,
    output logic signed [tsrmm_pkg::VAL_W-1:0]      min_value,
    output logic signed [tsrmm_pkg::VAL_W-1:0]      max_value
);
    import tsrmm_pkg::*;

    logic signed [VAL_W-1:0] mem [DEPTH];
    logic signed [VAL_W-1:0] rd_data_reg;
    logic signed [VAL_W-1:0] min_reg;
    logic signed [VAL_W-1:0] max_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[ctrl.wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[ctrl.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.acc_en) begin
            if (ctrl.acc_first || rd_data_reg < min_reg) begin
                min_reg <= rd_data_reg;
            end
            if (ctrl.acc_first || rd_data_reg > max_reg) begin
                max_reg <= rd_data_reg;
            end
        end
    end

    assign rd_data   = rd_data_reg;
    assign min_value = min_reg;
    assign max_value = max_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tsrmm_merge.sv
// ============================================================================
// tsrmm_merge
// Selects the lane result and holds it in the output register.
// ============================================================================
`default_nettype none

module tsrmm_merge (
    input  wire logic                                          aclk,
    input  wire logic                                          aresetn,
    input  wire tsrmm_pkg::out_load_t                          ld,
    input  wire logic [tsrmm_pkg::LANES-1:0][tsrmm_pkg::VAL_W-1:0] lane_rd,
    input  wire logic [tsrmm_pkg::LANES-1:0][tsrmm_pkg::VAL_W-1:0] lane_min,
    input  wire logic [tsrmm_pkg::LANES-1:0][tsrmm_pkg::VAL_W-1:0] lane_max,
    output logic                                               m_tvalid,
    input  wire logic                                          m_tready,
    // stored_count, sample_stamp, first_value, second_value, zero pad
    output logic [tsrmm_pkg::OUT_TDATA_W-1:0]                  m_tdata,
    // status, lane
    output logic [tsrmm_pkg::OUT_TUSER_W-1:0]                  m_tuser,
    output logic                                               m_tlast
);
    import tsrmm_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - CNT_W - STAMP_W - 2 * VAL_W;

    logic                     valid_reg;
    logic [OUT_TDATA_W-1:0]   data_reg;
    logic [OUT_TUSER_W-1:0]   user_reg;
    logic                     last_reg;
    logic [VAL_W-1:0]         first_sel;
    logic [VAL_W-1:0]         second_sel;

    always_comb begin
        first_sel  = '0;
        second_sel = '0;
        case (ld.src)
            SRC_READ: begin
                first_sel = lane_rd[ld.lane];
            end
            SRC_MINMAX: begin
                first_sel  = lane_min[ld.lane];
                second_sel = lane_max[ld.lane];
            end
            default: begin
                first_sel  = '0;
                second_sel = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (ld.load) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld.load) begin
            data_reg <= {{PAD_W{1'b0}}, second_sel, first_sel, ld.stamp, ld.count};
            user_reg <= {ld.lane, ld.status};
            last_reg <= ld.last;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/timed_sample_ring_minmax.sv
// ============================================================================
// timed_sample_ring_minmax
// Ring of timestamped samples with per-lane read and min/max scan.
// ============================================================================
// Commands arrive on the s_ stream; cmd travels in s_tuser. Results leave on
// the m_ stream, one per lane for read and non-empty min/max, one for the other cases;
// m_tlast marks the final result of a command. The cfg_ channel writes the
// window size and lane count and empties the ring; it is always ready.
// Push, clear, refused pushes and min/max on an empty ring load their result
// into the output register at the transfer, and a new command is taken in the
// next cycle when the output is not stalled, so these run at one per cycle.
// A read in range does one registered memory read; every read emits one result per lane.
// A min/max scan reads every held sample once through the lane memories
// working side by side in S_SCAN, then passes S_DRAIN and emits one result per lane.
// One command is in work at a time. When the receiver stalls, the output
// register holds its result and s_tready stays low until it is taken.
// Reset empties the ring, sets the window to 64 and the lane count to 1;
// the sample memories are not cleared.
// ============================================================================
`default_nettype none

module timed_sample_ring_minmax (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // sample_time, now_time, value_zero..value_three, given_count, position, pad
    input  wire logic [tsrmm_pkg::IN_TDATA_W-1:0]      s_tdata,
    // cmd
    input  wire logic [tsrmm_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // stored_count, sample_stamp, first_value, second_value, zero pad
    output logic [tsrmm_pkg::OUT_TDATA_W-1:0]          m_tdata,
    // status, lane
    output logic [tsrmm_pkg::OUT_TUSER_W-1:0]          m_tuser,
    output logic                                       m_tlast,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic [tsrmm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [tsrmm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import tsrmm_pkg::*;

    localparam int W = CNT_W + 1;

    state_t                  state_reg, state_next;
    logic [WIN_REG_W-1:0]    window_reg, window_next;
    logic [LANE_REG_W-1:0]   lanes_reg, lanes_next;
    logic [ADDR_W-1:0]       write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]        held_reg, held_next;
    logic [ADDR_W-1:0]       scan_slot_reg, scan_slot_next;
    logic [CNT_W-1:0]        scan_cnt_reg, scan_cnt_next;
    logic                    acc_v_reg, acc_v_next;
    logic                    acc_first_reg, acc_first_next;
    logic [LANE_W-1:0]       emit_lane_reg, emit_lane_next;
    src_t                    emit_src_reg, emit_src_next;
    status_t                 emit_status_reg, emit_status_next;

    logic [STAMP_W-1:0]      stamp_mem [DEPTH];
    logic [STAMP_W-1:0]      stamp_rd_reg;

    logic [CNT_W-1:0]        win;
    logic [LCNT_W-1:0]       nl;
    logic                    out_free;
    logic                    accept;
    logic                    cfg_hit;
    logic                    push_we;
    logic [STAMP_W-1:0]      push_stamp;
    logic [W-1:0]            oldest_x;
    logic [W-1:0]            read_x;
    logic [ADDR_W-1:0]       oldest;
    logic [ADDR_W-1:0]       read_slot;
    logic [ADDR_W-1:0]       ws_inc;
    logic [ADDR_W-1:0]       scan_inc;
    logic                    emit_last;

    cmd_t                    in_cmd;
    logic [STAMP_W-1:0]      in_sample_time;
    logic [STAMP_W-1:0]      in_now_time;
    logic [3:0]              in_given_count;
    logic [CNT_W-1:0]        in_position;
    logic [LANES-1:0][VAL_W-1:0] in_values;

    lane_ctrl_t              lane_ctrl;
    out_load_t               out_ld;
    logic [LANES-1:0]        lane_we;
    logic [LANES-1:0][VAL_W-1:0] lane_rd;
    logic [LANES-1:0][VAL_W-1:0] lane_min;
    logic [LANES-1:0][VAL_W-1:0] lane_max;

    assign in_cmd         = cmd_t'(s_tuser);
    assign in_sample_time = s_tdata[31:0];
    assign in_now_time    = s_tdata[63:32];
    assign in_values[0]   = s_tdata[95:64];
    assign in_values[1]   = s_tdata[127:96];
    assign in_values[2]   = s_tdata[159:128];
    assign in_values[3]   = s_tdata[191:160];
    assign in_given_count = s_tdata[195:192];
    assign in_position    = s_tdata[202:196];

    assign win = (window_reg == '0) ? CNT_W'(1) :
                 (window_reg > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : window_reg;
    assign nl  = (lanes_reg == '0) ? LCNT_W'(1) :
                 (lanes_reg > LCNT_W'(LANES)) ? LCNT_W'(LANES) : lanes_reg;

    assign out_free  = !m_tvalid || m_tready;
    assign s_tready  = (state_reg == S_IDLE) && out_free;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && (cfg_index == CFG_WINDOW || cfg_index == CFG_LANES);

    assign push_stamp = (in_sample_time != '0) ? in_sample_time : in_now_time;

    assign oldest_x  = (W'(write_slot_reg) >= W'(held_reg))
                     ? W'(write_slot_reg) - W'(held_reg)
                     : W'(write_slot_reg) + W'(win) - W'(held_reg);
    assign oldest    = oldest_x[ADDR_W-1:0];
    assign read_x    = ((oldest_x + W'(in_position)) >= W'(win))
                     ? oldest_x + W'(in_position) - W'(win)
                     : oldest_x + W'(in_position);
    assign read_slot = read_x[ADDR_W-1:0];

    assign ws_inc   = (W'(write_slot_reg) + W'(1) >= W'(win)) ? '0 : write_slot_reg + 1'b1;
    assign scan_inc = (W'(scan_slot_reg) + W'(1) >= W'(win)) ? '0 : scan_slot_reg + 1'b1;
    assign emit_last = (LCNT_W'(emit_lane_reg) == nl - LCNT_W'(1));

    always_comb begin
        state_next       = state_reg;
        window_next      = window_reg;
        lanes_next       = lanes_reg;
        write_slot_next  = write_slot_reg;
        held_next        = held_reg;
        scan_slot_next   = scan_slot_reg;
        scan_cnt_next    = scan_cnt_reg;
        acc_v_next       = 1'b0;
        acc_first_next   = acc_first_reg;
        emit_lane_next   = emit_lane_reg;
        emit_src_next    = emit_src_reg;
        emit_status_next = emit_status_reg;
        push_we          = 1'b0;

        lane_ctrl.wr_addr   = write_slot_reg;
        lane_ctrl.rd_en     = 1'b0;
        lane_ctrl.rd_addr   = read_slot;
        lane_ctrl.acc_en    = acc_v_reg;
        lane_ctrl.acc_first = acc_first_reg;

        out_ld.load   = 1'b0;
        out_ld.status = ST_OK;
        out_ld.count  = held_reg;
        out_ld.stamp  = '0;
        out_ld.lane   = '0;
        out_ld.last   = 1'b1;
        out_ld.src    = SRC_ZERO;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_PUSH: begin
                            out_ld.load = 1'b1;
                            if (in_given_count != 4'(nl)) begin
                                out_ld.status = ST_MISMATCH;
                            end else begin
                                push_we         = 1'b1;
                                write_slot_next = ws_inc;
                                if (held_reg < win) begin
                                    held_next = held_reg + 1'b1;
                                end
                                out_ld.count = held_next;
                            end
                        end
                        CMD_CLEAR: begin
                            out_ld.load     = 1'b1;
                            write_slot_next = '0;
                            held_next       = '0;
                            out_ld.count    = '0;
                        end
                        CMD_READ: begin
                            state_next     = S_EMIT;
                            emit_lane_next = '0;
                            if (in_position < held_reg) begin
                                lane_ctrl.rd_en  = 1'b1;
                                emit_src_next    = SRC_READ;
                                emit_status_next = ST_OK;
                            end else begin
                                emit_src_next    = SRC_ZERO;
                                emit_status_next = ST_RANGE;
                            end
                        end
                        CMD_MINMAX: begin
                            if (held_reg == '0) begin
                                out_ld.load   = 1'b1;
                                out_ld.status = ST_EMPTY;
                            end else begin
                                state_next       = S_SCAN;
                                scan_slot_next   = oldest;
                                scan_cnt_next    = '0;
                                emit_src_next    = SRC_MINMAX;
                                emit_status_next = ST_OK;
                            end
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                lane_ctrl.rd_en   = 1'b1;
                lane_ctrl.rd_addr = scan_slot_reg;
                acc_v_next        = 1'b1;
                acc_first_next    = (scan_cnt_reg == '0);
                scan_slot_next    = scan_inc;
                scan_cnt_next     = scan_cnt_reg + 1'b1;
                if (scan_cnt_reg == held_reg - 1'b1) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next     = S_EMIT;
                emit_lane_next = '0;
            end
            S_EMIT: begin
                if (out_free) begin
                    out_ld.load   = 1'b1;
                    out_ld.status = emit_status_reg;
                    out_ld.stamp  = (emit_src_reg == SRC_READ) ? stamp_rd_reg : '0;
                    out_ld.lane   = emit_lane_reg;
                    out_ld.last   = emit_last;
                    out_ld.src    = emit_src_reg;
                    if (emit_last) begin
                        state_next = S_IDLE;
                    end else begin
                        emit_lane_next = emit_lane_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_WINDOW: window_next = cfg_data;
                CFG_LANES:  lanes_next  = cfg_data[LANE_REG_W-1:0];
                default:    window_next = window_reg;
            endcase
        end
        if (cfg_hit) begin
            write_slot_next = '0;
            held_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            window_reg     <= WIN_REG_W'(DEPTH);
            lanes_reg      <= LANE_REG_W'(1);
            write_slot_reg <= '0;
            held_reg       <= '0;
            acc_v_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            window_reg     <= window_next;
            lanes_reg      <= lanes_next;
            write_slot_reg <= write_slot_next;
            held_reg       <= held_next;
            acc_v_reg      <= acc_v_next;
        end
    end

    always_ff @(posedge aclk) begin
        scan_slot_reg   <= scan_slot_next;
        scan_cnt_reg    <= scan_cnt_next;
        acc_first_reg   <= acc_first_next;
        emit_lane_reg   <= emit_lane_next;
        emit_src_reg    <= emit_src_next;
        emit_status_reg <= emit_status_next;
    end

    always_ff @(posedge aclk) begin
        if (push_we) begin
            stamp_mem[write_slot_reg] <= push_stamp;
        end
        if (lane_ctrl.rd_en) begin
            stamp_rd_reg <= stamp_mem[lane_ctrl.rd_addr];
        end
    end

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        assign lane_we[j] = push_we && (LCNT_W'(j) < nl);

        tsrmm_lane u_lane (
            .aclk      (aclk),
            .ctrl      (lane_ctrl),
            .wr_en     (lane_we[j]),
            .wr_data   (in_values[j]),
            .rd_data   (lane_rd[j]),
            .min_value (lane_min[j]),
            .max_value (lane_max[j])
        );
    end

    tsrmm_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ld       (out_ld),
        .lane_rd  (lane_rd),
        .lane_min (lane_min),
        .lane_max (lane_max),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: tb/timed_sample_ring_minmax_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// timed_sample_ring_minmax_tb
// Self-checking testbench for the timed sample ring with per-lane min/max.
// ============================================================================
// Commands go in as stream transfers and are mirrored by a behavioral model
// of the ring. The model queues the results that each accepted command must
// produce, and every result transfer is compared field by field with the
// oldest one queued. Directed tests cover the empty ring, refused pushes,
// zero stamps, value extremes and the register special cases. Random
// phases then run under several window and lane settings with random gaps
// on both sides, and a final test holds off the receiver for a long
// stretch so that the ring stalls its input.
// ============================================================================

module timed_sample_ring_minmax_tb;

    import tsrmm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_NONE = 2'd3;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        cmd_t             cmd;
        logic [31:0]      sample_time;
        logic [31:0]      now_time;
        logic [3:0][31:0] value;
        logic [3:0]       given_count;
        logic [6:0]       position;
    } ring_cmd_t;

    typedef struct packed {
        status_t     status;
        logic [6:0]  count;
        logic [31:0] stamp;
        logic [1:0]  lane;
        logic [31:0] first_value;
        logic [31:0] second_value;
        logic        last;
    } ring_result_t;

    logic                   aclk;
    logic                   aresetn = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic [IN_TUSER_W-1:0]  s_tuser = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [OUT_TUSER_W-1:0] m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // Behavioral copy of the ring and its registers.
    logic [31:0]  ring_stamp [DEPTH];
    logic [31:0]  ring_value [DEPTH][LANES];
    int unsigned  ring_wr = 0;
    int unsigned  ring_held = 0;
    logic [6:0]   win_reg = 7'd64;
    logic [2:0]   lanes_reg = 3'd1;

    ring_result_t awaited_results [$];
    int           error_count = 0;
    int           gap_pct = 0;
    int           stall_pct = 0;
    int           hold_ask = 0;
    int           hold_seen = 0;
    int           hold_left = 0;

    timed_sample_ring_minmax u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    initial begin
        #8_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic int unsigned lane_count();
        if (lanes_reg == 3'd0) return 1;
        if (lanes_reg > LANES) return LANES;
        return lanes_reg;
    endfunction

    function automatic void await_result(input status_t st, input logic [31:0] stamp,
                                         input int unsigned lane, input logic [31:0] lo,
                                         input logic [31:0] hi, input bit last);
        ring_result_t r;
        r.status       = st;
        r.count        = 7'(ring_held);
        r.stamp        = stamp;
        r.lane         = 2'(lane);
        r.first_value  = lo;
        r.second_value = hi;
        r.last         = last;
        awaited_results.push_back(r);
    endfunction

    function automatic void predict_ring(input ring_cmd_t it);
        int unsigned win;
        int unsigned nl;
        int unsigned slot;
        int unsigned oldest;
        int unsigned j;
        int unsigned i;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        logic signed [31:0] v;
        win = (win_reg == 7'd0) ? 1 : ((win_reg > DEPTH) ? DEPTH : win_reg);
        nl = lane_count();
        if (ring_wr >= win) ring_wr = 0;
        if (ring_held > win) ring_held = win;
        case (it.cmd)
            CMD_PUSH: begin
                if (it.given_count != nl) begin
                    await_result(ST_MISMATCH, '0, 0, '0, '0, 1'b1);
                end else begin
                    for (j = 0; j < nl; j++) ring_value[ring_wr][j] = it.value[j];
                    ring_stamp[ring_wr] = (it.sample_time != 0) ? it.sample_time : it.now_time;
                    ring_wr = (ring_wr + 1 >= win) ? 0 : ring_wr + 1;
                    if (ring_held < win) ring_held++;
                    await_result(ST_OK, '0, 0, '0, '0, 1'b1);
                end
            end
            CMD_CLEAR: begin
                ring_wr = 0;
                ring_held = 0;
                await_result(ST_OK, '0, 0, '0, '0, 1'b1);
            end
            default: begin
                oldest = (ring_wr >= ring_held) ? ring_wr - ring_held
                                                : ring_wr + win - ring_held;
                if (it.cmd == CMD_READ) begin
                    if (it.position >= ring_held) begin
                        for (j = 0; j < nl; j++)
                            await_result(ST_RANGE, '0, j, '0, '0, j + 1 == nl);
                    end else begin
                        slot = oldest + it.position;
                        if (slot >= win) slot -= win;
                        for (j = 0; j < nl; j++)
                            await_result(ST_OK, ring_stamp[slot], j, ring_value[slot][j], '0,
                                         j + 1 == nl);
                    end
                end else if (ring_held == 0) begin
                    await_result(ST_EMPTY, '0, 0, '0, '0, 1'b1);
                end else begin
                    for (j = 0; j < nl; j++) begin
                        lo = ring_value[oldest][j];
                        hi = lo;
                        slot = oldest;
                        for (i = 0; i < ring_held; i++) begin
                            v = ring_value[slot][j];
                            if (v < lo) lo = v;
                            if (v > hi) hi = v;
                            slot = (slot + 1 >= win) ? 0 : slot + 1;
                        end
                        await_result(ST_OK, '0, j, lo, hi, j + 1 == nl);
                    end
                end
            end
        endcase
    endfunction

    always @(posedge aclk) begin : check_results
        ring_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                report_error("result transfer with no result outstanding");
            end else begin
                want = awaited_results.pop_front();
                if (m_tuser[1:0] !== want.status)
                    report_error($sformatf("status got %0d want %0d", m_tuser[1:0],
                                           want.status));
                if (m_tdata[6:0] !== want.count)
                    report_error($sformatf("stored_count got %0d want %0d", m_tdata[6:0],
                                           want.count));
                if (m_tdata[38:7] !== want.stamp)
                    report_error($sformatf("sample_stamp got %h want %h", m_tdata[38:7],
                                           want.stamp));
                if (m_tuser[3:2] !== want.lane)
                    report_error($sformatf("lane got %0d want %0d", m_tuser[3:2], want.lane));
                if (m_tdata[70:39] !== want.first_value)
                    report_error($sformatf("first_value got %h want %h", m_tdata[70:39],
                                           want.first_value));
                if (m_tdata[102:71] !== want.second_value)
                    report_error($sformatf("second_value got %h want %h", m_tdata[102:71],
                                           want.second_value));
                if (m_tlast !== want.last)
                    report_error($sformatf("last_of_run got %b want %b", m_tlast, want.last));
            end
        end
    end

    // The receiver stalls at random, or holds off for a long stretch on request.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ask != hold_seen) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_seen <= hold_ask;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic send_item(input ring_cmd_t it);
        while ($urandom_range(99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {5'b0, it.position, it.given_count, it.value[3], it.value[2],
                     it.value[1], it.value[0], it.now_time, it.sample_time};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_ring(it);
    endtask

    task automatic drain_results(input int settle);
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        drain_results(4);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        if (idx == CFG_WINDOW || idx == CFG_LANES) begin
            if (idx == CFG_WINDOW) win_reg = data;
            else lanes_reg = data[2:0];
            ring_wr = 0;
            ring_held = 0;
        end
    endtask

    task automatic set_idling(input int gap, input int stall);
        gap_pct = gap;
        stall_pct <= stall;
    endtask

    function automatic ring_cmd_t draw_command(input cmd_t c);
        ring_cmd_t it;
        int j;
        it.cmd = c;
        it.sample_time = ($urandom_range(7) == 0) ? 32'd0 : $urandom;
        it.now_time = $urandom;
        for (j = 0; j < 4; j++) begin
            case ($urandom_range(7))
                0:       it.value[j] = 32'h8000_0000;
                1:       it.value[j] = 32'h7FFF_FFFF;
                2:       it.value[j] = 32'h0000_0000;
                3:       it.value[j] = 32'hFFFF_FFFF;
                default: it.value[j] = $urandom;
            endcase
        end
        it.given_count = 4'(lane_count());
        it.position = 7'($urandom_range(127));
        return it;
    endfunction

    task automatic send_random_mix(input int n);
        ring_cmd_t it;
        int k;
        int r;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(99);
            if (r < 55) begin
                it = draw_command(CMD_PUSH);
                if ($urandom_range(9) == 0) it.given_count = 4'($urandom_range(15));
            end else if (r < 75) begin
                it = draw_command(CMD_READ);
                if (ring_held > 0 && $urandom_range(6) != 0)
                    it.position = 7'($urandom_range(ring_held - 1));
            end else if (r < 90) begin
                it = draw_command(CMD_MINMAX);
            end else if (r < 93) begin
                it = draw_command(CMD_CLEAR);
            end else begin
                it = draw_command(cmd_t'($urandom_range(3)));
                it.given_count = 4'($urandom_range(15));
            end
            send_item(it);
        end
    endtask

    task automatic test_empty_and_push();
        ring_cmd_t it;
        send_item(draw_command(CMD_MINMAX));
        it = draw_command(CMD_READ);
        it.position = 7'd0;
        send_item(it);
        it.position = 7'd127;
        send_item(it);
        it = draw_command(CMD_PUSH);
        it.given_count = 4'd0;
        send_item(it);
        it.given_count = 4'd15;
        send_item(it);
        it = draw_command(CMD_PUSH);
        it.sample_time = 32'd0;
        it.now_time = 32'hFFFF_FFFF;
        it.value[0] = 32'h0000_0000;
        send_item(it);
        it = draw_command(CMD_PUSH);
        it.sample_time = 32'hFFFF_FFFF;
        it.value[0] = 32'h7FFF_FFFF;
        send_item(it);
        it.sample_time = 32'd1;
        it.value[0] = 32'h8000_0000;
        send_item(it);
        it = draw_command(CMD_READ);
        for (int p = 0; p < 4; p++) begin
            it.position = 7'(p);
            send_item(it);
        end
        send_item(draw_command(CMD_MINMAX));
        send_item(draw_command(CMD_CLEAR));
        it.position = 7'd0;
        send_item(it);
        send_item(draw_command(CMD_MINMAX));
    endtask

    task automatic test_register_writes();
        ring_cmd_t it;
        send_item(draw_command(CMD_PUSH));
        write_register(CFG_NONE, 7'h7F);
        it = draw_command(CMD_READ);
        it.position = 7'd0;
        send_item(it);
        write_register(CFG_LANES, 7'd7);
        it = draw_command(CMD_PUSH);
        it.given_count = 4'd7;
        send_item(it);
        it = draw_command(CMD_PUSH);
        it.value = {32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001};
        send_item(it);
        it.value = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 32'hFFFF_FFFF};
        send_item(it);
        it = draw_command(CMD_READ);
        it.position = 7'd1;
        send_item(it);
        send_item(draw_command(CMD_MINMAX));
        write_register(CFG_WINDOW, 7'd0);
        write_register(CFG_LANES, 7'd0);
        send_item(draw_command(CMD_PUSH));
        send_item(draw_command(CMD_PUSH));
        it = draw_command(CMD_READ);
        it.position = 7'd0;
        send_item(it);
        it.position = 7'd1;
        send_item(it);
        send_item(draw_command(CMD_MINMAX));
    endtask

    task automatic test_random_phases();
        logic [6:0] wins [8];
        logic [2:0] lns [8];
        int p;
        wins = '{7'd1, 7'd64, 7'd5, 7'd127, 7'd0, 7'd3, 7'd17, 7'd65};
        lns  = '{3'd4, 3'd1, 3'd7, 3'd2, 3'd0, 3'd3, 3'd5, 3'd4};
        for (p = 0; p < 8; p++) begin
            write_register(CFG_WINDOW, wins[p]);
            write_register(CFG_LANES, {4'($urandom_range(15)), lns[p]});
            case (p % 4)
                0:       set_idling(0, 0);
                1:       set_idling(51, 0);
                2:       set_idling(0, 51);
                default: set_idling(38, 38);
            endcase
            send_random_mix(50);
        end
    endtask

    task automatic test_receiver_hold();
        write_register(CFG_WINDOW, 7'd8);
        write_register(CFG_LANES, 7'd4);
        set_idling(0, 0);
        send_random_mix(12);
        hold_ask <= hold_ask + 1;
        send_random_mix(20);
        drain_results(4);
        set_idling(38, 38);
        send_random_mix(12);
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        test_empty_and_push();
        test_register_writes();
        test_random_phases();
        test_receiver_hold();
        drain_results(100);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/tsrmm_pkg.sv
hw/rtl/tsrmm_lane.sv
hw/rtl/tsrmm_merge.sv
hw/rtl/timed_sample_ring_minmax.sv
tb/timed_sample_ring_minmax_tb.sv
